FILE: hdl/lzw_pkg.sv
// Shared types and constants of the LZW encoder.
// Depends on nothing; lzw_encoder, lzw_ctrl and lzw_dpath import it.
package lzw_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CODE_W      = 12;
  localparam int unsigned LIT_CODES   = 256;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;          // capture the accepted item
    logic start_stream;  // first byte: becomes the prefix, mark started
    logic scan_start;    // rewind the dictionary scan to the first learned code
    logic scan_en;       // advance the dictionary scan one entry
    logic hit_load;      // matched entry becomes the prefix
    logic emit;          // load the output register with the prefix code
    logic emit_last;     // flag the loaded code as the last of the stream
    logic learn;         // store prefix and byte at the next free code, if one is left
    logic restart_byte;  // prefix restarts from the held byte
    logic stream_reset;  // back to the state after reset
  } lzw_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic started;   // a stream is in progress
    logic eos;       // held item is the last of its stream
    logic hit;       // scan found prefix and byte
    logic miss;      // scan ran past the last learned code
    logic out_free;  // output register can take a code this cycle
  } lzw_stat_t;

endpackage

FILE: hdl/lzw_encoder.sv
// LZW encoder: one byte per item in, dictionary codes out, one scan per byte after the first.
// The first byte of a stream becomes the prefix; each later byte starts a scan of the learned
// codes, read one entry a cycle through the RAM's registered read port. The block takes no new
// byte while it scans or waits to emit a code; the output register lets the next byte enter
// while a code waits in it. Reset (async, active low) clears control state; the dictionary
// is never cleared, no clearing pass, entries reused.
module lzw_encoder #(
  parameter int unsigned DICT_ENTRIES = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [lzw_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [7:0] in_byte
  input  logic                             s_axis_tlast,  // end_of_stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [lzw_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [11:0] code, [15:12] zero
  output logic                             m_axis_tlast   // last_code
);
  import lzw_pkg::*;

  lzw_cmd_t  cmd;
  lzw_stat_t stat;

  // Sequencer
  lzw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // Registers, dictionary and output stage
  lzw_dpath #(
    .DICT_ENTRIES(DICT_ENTRIES)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule

FILE: hdl/lzw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module lzw_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/lzw_ctrl.sv
// Controller of the LZW encoder: sequences capture, scan, emit and learn.
// Depends on lzw_pkg for the command and status structs.
module lzw_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lzw_pkg::lzw_stat_t stat_i,
  output lzw_pkg::lzw_cmd_t  cmd_o
);
  import lzw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_EMIT_MISS,
    ST_EMIT_LAST
  } state_e;

  state_e state_q, state_d;

  // Decode state into commands and next state
  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!stat_i.started) begin
          cmd_o.start_stream = 1'b1;
          state_d            = stat_i.eos ? ST_EMIT_LAST : ST_IDLE;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (stat_i.hit) begin
          cmd_o.hit_load = 1'b1;
          state_d        = stat_i.eos ? ST_EMIT_LAST : ST_IDLE;
        end else if (stat_i.miss) begin
          state_d = ST_EMIT_MISS;
        end
      end
      ST_EMIT_MISS: begin
        if (stat_i.out_free) begin
          cmd_o.emit         = 1'b1;
          cmd_o.learn        = 1'b1;
          cmd_o.restart_byte = 1'b1;
          state_d            = stat_i.eos ? ST_EMIT_LAST : ST_IDLE;
        end
      end
      ST_EMIT_LAST: begin
        if (stat_i.out_free) begin
          cmd_o.emit         = 1'b1;
          cmd_o.emit_last    = 1'b1;
          cmd_o.stream_reset = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/lzw_dpath.sv
// Datapath of the LZW encoder: item capture, prefix and free-code registers,
// dictionary RAM with its linear scan, and the output register.
// Depends on lzw_pkg and lzw_ram.
module lzw_dpath #(
  parameter int unsigned DICT_ENTRIES = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [lzw_pkg::IN_TDATA_W-1:0]   in_data_i,
  input  logic                             in_last_i,
  input  lzw_pkg::lzw_cmd_t                cmd_i,
  output lzw_pkg::lzw_stat_t               stat_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [lzw_pkg::OUT_TDATA_W-1:0]  out_data_o,
  output logic                             out_last_o
);
  import lzw_pkg::*;

  localparam int unsigned CW = $clog2(DICT_ENTRIES);
  localparam int unsigned NW = $clog2(DICT_ENTRIES + 1);
  localparam int unsigned EW = CW + BYTE_W;

  logic [BYTE_W-1:0] byte_q;
  logic              eos_q;
  logic              started_q;
  logic [CW-1:0]     prefix_q;
  logic [NW-1:0]     next_free_q;
  logic [NW-1:0]     addr_q;
  logic              pend_q;
  logic [CW-1:0]     pend_addr_q;
  logic              out_valid_q;
  logic [CODE_W-1:0] out_code_q;
  logic              out_last_q;

  logic          addr_lt;
  logic          room;
  logic          ram_we;
  logic [EW-1:0] ram_rdata;
  logic          hit;
  logic          miss;
  logic          out_free;

  // Scan compare and bounds
  assign addr_lt  = addr_q < next_free_q;
  assign room     = next_free_q < NW'(DICT_ENTRIES);
  assign ram_we   = cmd_i.learn && room;
  assign hit      = pend_q && (ram_rdata == {prefix_q, byte_q});
  assign miss     = !pend_q && !addr_lt;
  assign out_free = !out_valid_q || out_ready_i;

  assign stat_o.started  = started_q;
  assign stat_o.eos      = eos_q;
  assign stat_o.hit      = hit;
  assign stat_o.miss     = miss;
  assign stat_o.out_free = out_free;

  // Dictionary of learned (prefix, byte) pairs
  lzw_ram #(
    .WIDTH(EW),
    .DEPTH(DICT_ENTRIES)
  ) u_dict (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(next_free_q[CW-1:0]),
    .wdata_i({prefix_q, byte_q}),
    .raddr_i(addr_q[CW-1:0]),
    .rdata_o(ram_rdata)
  );

  // Control registers: stream flag, free code, scan pointer, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      next_free_q <= NW'(LIT_CODES);
      addr_q      <= NW'(LIT_CODES);
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.stream_reset) begin
        started_q   <= 1'b0;
        next_free_q <= NW'(LIT_CODES);
      end else begin
        if (cmd_i.start_stream) begin
          started_q <= 1'b1;
        end
        if (ram_we) begin
          next_free_q <= next_free_q + NW'(1);
        end
      end
      // advance the scan one entry a cycle while entries remain
      if (cmd_i.scan_start) begin
        addr_q <= NW'(LIT_CODES);
        pend_q <= 1'b0;
      end else if (cmd_i.scan_en) begin
        pend_q <= addr_lt;
        if (addr_lt) begin
          addr_q <= addr_q + NW'(1);
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: held item, prefix, scan address in flight, output code
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      byte_q <= in_data_i[BYTE_W-1:0];
      eos_q  <= in_last_i;
    end
    if (cmd_i.stream_reset) begin
      prefix_q <= '0;
    end else if (cmd_i.hit_load) begin
      prefix_q <= pend_addr_q;
    end else if (cmd_i.start_stream || cmd_i.restart_byte) begin
      prefix_q <= CW'(byte_q);
    end
    if (cmd_i.scan_en) begin
      pend_addr_q <= addr_q[CW-1:0];
    end
    if (cmd_i.emit) begin
      out_code_q <= CODE_W'(prefix_q);
      out_last_q <= cmd_i.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = OUT_TDATA_W'(out_code_q);
  assign out_last_o  = out_last_q;

  // Free code stays within the learned range
  a_free_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_free_q >= NW'(LIT_CODES)) && (next_free_q <= NW'(DICT_ENTRIES)))
    else $error("next free code out of range");

  // A taken match only ever comes from a learned entry
  a_hit_learned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.hit_load |->
      (NW'(pend_addr_q) >= NW'(LIT_CODES)) && (NW'(pend_addr_q) < next_free_q))
    else $error("match on an entry that was never learned");

  // A code is loaded only when the output register can take it
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("output code overwritten before it was taken");

  // End of stream returns to the reset state
  a_stream_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.stream_reset |=> (next_free_q == NW'(LIT_CODES)) && !started_q)
    else $error("stream state not cleared after last code");

endmodule
